// ===== src/msaa_pkg.sv =====
package msaa_pkg;

   localparam int CH_W       = 16;
   localparam int NUM_CH     = 3;
   localparam int W_W        = 9;
   localparam int W_ONE      = 256;
   localparam int NUM_WEIGHT = 4;
   localparam int CNT_CFG_W  = 3;
   localparam int SIZE_CFG_W = 13;
   localparam int SUM_W      = 27;
   localparam int WSUM_W     = 11;
   localparam int QUO_W      = 16;
   localparam int PROD_W     = CH_W + W_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int DEF_MAX_SAMPLES = 4;
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_MAX_HEIGHT  = 4096;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_THREE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

   localparam logic [CNT_CFG_W-1:0]  RST_SAMPLE_COUNT = 3'd1;
   localparam logic [W_W-1:0]        RST_WEIGHT       = 9'd256;
   localparam logic [SIZE_CFG_W-1:0] RST_FRAME_SIZE   = 13'd2;

   typedef logic [CH_W-1:0] chan_type;

   typedef struct packed {
      logic [CNT_CFG_W-1:0]             sample_count;
      logic [NUM_WEIGHT-1:0][W_W-1:0]   weight;
      logic [SIZE_CFG_W-1:0]            frame_width;
      logic [SIZE_CFG_W-1:0]            frame_height;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic pixel_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/msaa_req_if.sv =====
interface msaa_req_if import msaa_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red_in;
   chan_type green_in;
   chan_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ===== src/msaa_rsp_if.sv =====
interface msaa_rsp_if import msaa_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red_out;
   chan_type green_out;
   chan_type blue_out;
   logic     frame_end;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output frame_end, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input frame_end, output ready);
endinterface

// ===== src/msaa_csr_if.sv =====
interface msaa_csr_if import msaa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/msaa_weighted_resolve.sv =====
// Weighted multisample resolve. Samples (RGB, unsigned Q8.8) enter in raster
// order, sample_count per pixel, and each is scaled by its Q1.8 weight and
// summed; one sample is taken per cycle while accepting. On a pixel's last
// sample the three sums are divided by the weight total in a restoring
// divider (a subtractor per channel, shared divisor and step control) that
// yields one quotient bit per cycle for all three channels over 16 steps,
// and the result is then loaded; no sample is taken during the divide or
// the load. A quotient above 0xFFFF saturates, and a zero weight total
// gives zero. The result sits in an output register, so the next pixel's
// samples flow while it waits to be taken. frame_end marks the last pixel
// of each frame. Registers are written through the csr port, which is always ready.
module msaa_weighted_resolve import msaa_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   msaa_req_if.sink   req_if,
   msaa_rsp_if.source rsp_if,
   msaa_csr_if.sink   csr_if
);

   cfg_type               cfg;
   dp_cmd_type            cmd;
   dp_status_type         status;
   chan_type [NUM_CH-1:0] in_chan;
   chan_type [NUM_CH-1:0] out_chan;
   logic                  rsp_valid;
   logic                  frame_end;

   assign in_chan[0] = req_if.red_in;
   assign in_chan[1] = req_if.green_in;
   assign in_chan[2] = req_if.blue_in;

   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.red_out   = out_chan[0];
   assign rsp_if.green_out = out_chan[1];
   assign rsp_if.blue_out  = out_chan[2];
   assign rsp_if.frame_end = frame_end;

   msaa_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   msaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msaa_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .in_chan   (in_chan),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .out_chan  (out_chan),
      .frame_end (frame_end)
   );

endmodule

// ===== src/msaa_csr.sv =====
module msaa_csr import msaa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   msaa_csr_if.sink csr,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_SAMPLE_COUNT: cfg_in.sample_count = csr.data[CNT_CFG_W-1:0];
            REG_WEIGHT_ZERO:  cfg_in.weight[0]    = csr.data[W_W-1:0];
            REG_WEIGHT_ONE:   cfg_in.weight[1]    = csr.data[W_W-1:0];
            REG_WEIGHT_TWO:   cfg_in.weight[2]    = csr.data[W_W-1:0];
            REG_WEIGHT_THREE: cfg_in.weight[3]    = csr.data[W_W-1:0];
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr.data[SIZE_CFG_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr.data[SIZE_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count <= RST_SAMPLE_COUNT;
         cfg_ff.weight       <= {NUM_WEIGHT{RST_WEIGHT}};
         cfg_ff.frame_width  <= RST_FRAME_SIZE;
         cfg_ff.frame_height <= RST_FRAME_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/msaa_ctrl.sv =====
module msaa_ctrl import msaa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_LOAD   = 2'd2;

   localparam int STEP_W = $clog2(QUO_W);

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   assign req_ready  = (state_ff == ST_ACCEPT);
   assign cmd.accept = req_valid && (state_ff == ST_ACCEPT);
   assign cmd.step   = (state_ff == ST_DIVIDE);
   assign cmd.load   = (state_ff == ST_LOAD) && status.out_free;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            step_in = '0;
            if (cmd.accept && status.pixel_last) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/msaa_dp.sv =====
module msaa_dp import msaa_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  chan_type [NUM_CH-1:0]   in_chan,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output chan_type [NUM_CH-1:0]   out_chan,
   output logic                    frame_end
);

   localparam int SI_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SC_W  = (SI_W + 1 > CNT_CFG_W) ? SI_W + 1 : CNT_CFG_W;
   localparam int WI_W  = (SI_W > 2) ? SI_W : 2;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int XW    = (COL_W + 1 > SIZE_CFG_W) ? COL_W + 1 : SIZE_CFG_W;
   localparam int YW    = (ROW_W + 1 > SIZE_CFG_W) ? ROW_W + 1 : SIZE_CFG_W;
   localparam int HI_W  = SUM_W - QUO_W;

   logic [SI_W-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [NUM_CH-1:0][SUM_W-1:0] acc_ff, acc_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;

   logic [NUM_CH-1:0][HI_W-1:0]  rem_ff, rem_in;
   logic [NUM_CH-1:0][QUO_W-1:0] quo_ff, quo_in;
   logic [NUM_CH-1:0]            sat_ff, sat_in;
   logic [WSUM_W-1:0]            den_ff, den_in;
   logic                         zero_ff, zero_in;
   logic                         fend_ff, fend_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   chan_type [NUM_CH-1:0]        out_ff, out_in;
   logic                         rsp_fend_ff, rsp_fend_in;

   logic [SC_W-1:0]  count;
   logic [XW-1:0]    width;
   logic [YW-1:0]    height;
   logic [WI_W-1:0]  widx;
   logic [W_W-1:0]   wraw;
   logic [W_W-1:0]   weight;
   logic             last_sample;
   logic             last_col;
   logic             last_row;
   logic [NUM_CH-1:0][PROD_W-1:0] prod;
   logic [NUM_CH-1:0][SUM_W-1:0]  sum_next;
   logic [WSUM_W-1:0]             wsum_next;
   logic [NUM_CH-1:0][HI_W:0]     trial;
   logic [NUM_CH-1:0][HI_W:0]     diff;

   always_comb begin
      count = SC_W'(cfg.sample_count);
      if (count == '0) begin
         count = SC_W'(1);
      end else if (count > SC_W'(MAX_SAMPLES)) begin
         count = SC_W'(MAX_SAMPLES);
      end
      width = XW'(cfg.frame_width);
      if (width == '0) begin
         width = XW'(1);
      end else if (width > XW'(MAX_WIDTH)) begin
         width = XW'(MAX_WIDTH);
      end
      height = YW'(cfg.frame_height);
      if (height == '0) begin
         height = YW'(1);
      end else if (height > YW'(MAX_HEIGHT)) begin
         height = YW'(MAX_HEIGHT);
      end
      widx   = WI_W'(idx_ff);
      wraw   = cfg.weight[widx[1:0]];
      weight = (wraw > W_W'(W_ONE)) ? W_W'(W_ONE) : wraw;
      last_sample = (SC_W'(idx_ff) + 1'b1) >= count;
      last_col    = (XW'(col_ff) + 1'b1) >= width;
      last_row    = (YW'(row_ff) + 1'b1) >= height;
   end

   assign status.pixel_last = last_sample;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c]     = in_chan[c] * weight;
         sum_next[c] = acc_ff[c] + SUM_W'(prod[c]);
         trial[c]    = {rem_ff[c], quo_ff[c][QUO_W-1]};
         diff[c]     = trial[c] - (HI_W + 1)'(den_ff);
      end
      wsum_next = wsum_ff + WSUM_W'(weight);
   end

   always_comb begin
      idx_in  = idx_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      acc_in  = acc_ff;
      wsum_in = wsum_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      den_in  = den_ff;
      zero_in = zero_ff;
      fend_in = fend_ff;
      if (cmd.accept) begin
         if (last_sample) begin
            idx_in  = '0;
            acc_in  = '0;
            wsum_in = '0;
            for (int c = 0; c < NUM_CH; c++) begin
               rem_in[c] = sum_next[c][SUM_W-1:QUO_W];
               quo_in[c] = sum_next[c][QUO_W-1:0];
               sat_in[c] = HI_W'(sum_next[c][SUM_W-1:QUO_W]) >= HI_W'(wsum_next);
            end
            den_in  = wsum_next;
            zero_in = (wsum_next == '0);
            fend_in = last_col && last_row;
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            idx_in  = idx_ff + 1'b1;
            acc_in  = sum_next;
            wsum_in = wsum_next;
         end
      end else if (cmd.step) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (!diff[c][HI_W]) begin
               rem_in[c] = diff[c][HI_W-1:0];
               quo_in[c] = {quo_ff[c][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[c] = trial[c][HI_W-1:0];
               quo_in[c] = {quo_ff[c][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      rsp_fend_in  = rsp_fend_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_fend_in  = fend_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            if (zero_ff) begin
               out_in[c] = '0;
            end else if (sat_ff[c]) begin
               out_in[c] = '1;
            end else begin
               out_in[c] = quo_ff[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         acc_ff       <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         acc_ff       <= acc_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      den_ff      <= den_in;
      zero_ff     <= zero_in;
      fend_ff     <= fend_in;
      out_ff      <= out_in;
      rsp_fend_ff <= rsp_fend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_chan  = out_ff;
   assign frame_end = rsp_fend_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !zero_ff && !sat_ff[0]) |-> (HI_W'(den_ff) > rem_ff[0]))
      else $error("red remainder not below divisor");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load))
      else $error("result raised without load");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && last_sample) |=> (wsum_ff == '0 && idx_ff == '0))
      else $error("pixel close left accumulators set");

   a_no_load_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load)
      else $error("output overwritten while stalled");

endmodule

// ===== sim/msaa_weighted_resolve_tb.sv =====
`timescale 1ns / 1ps

module msaa_weighted_resolve_tb import msaa_pkg::*; ();

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int SAMPLE_TARGET = 950;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     frame_end;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   msaa_req_if req_bus ();
   msaa_rsp_if rsp_bus ();
   msaa_csr_if csr_bus ();

   msaa_weighted_resolve dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // resolve predictor state
   cfg_type                 model_cfg;
   logic [1:0]              sample_idx;
   logic [11:0]             pix_col;
   logic [11:0]             pix_row;
   logic [SUM_W-1:0]        red_acc;
   logic [SUM_W-1:0]        green_acc;
   logic [SUM_W-1:0]        blue_acc;
   logic [WSUM_W-1:0]       weight_acc;
   pixel_type               expected_pixels[$];

   int samples_sent   = 0;
   int pixels_checked = 0;
   int frame_ends     = 0;
   int csr_writes     = 0;
   int fail_count     = 0;
   int burst_left     = 0;

   // receiver stall pattern
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int mode_left     = 0;
   int stall_mode    = 0;
   int stall_phase   = 0;

   function automatic int samples_per_pixel();
      if (model_cfg.sample_count == 0) return 1;
      if (model_cfg.sample_count > DEF_MAX_SAMPLES) return DEF_MAX_SAMPLES;
      return int'(model_cfg.sample_count);
   endfunction

   function automatic int clamp_size(logic [SIZE_CFG_W-1:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic chan_type resolve_channel(logic [SUM_W-1:0] sum,
                                                logic [WSUM_W-1:0] wsum);
      logic [SUM_W-1:0] q;
      if (wsum == 0) return '0;
      q = sum / wsum;
      return (q > 16'hFFFF) ? 16'hFFFF : q[CH_W-1:0];
   endfunction

   function automatic void fold_sample(chan_type r, chan_type g, chan_type b);
      int unsigned w_eff;
      pixel_type   px;
      logic        last_col;
      logic        last_row;
      w_eff = (model_cfg.weight[sample_idx] > W_ONE) ? W_ONE : model_cfg.weight[sample_idx];
      red_acc    = red_acc + SUM_W'(r * w_eff);
      green_acc  = green_acc + SUM_W'(g * w_eff);
      blue_acc   = blue_acc + SUM_W'(b * w_eff);
      weight_acc = weight_acc + WSUM_W'(w_eff);
      if (int'(sample_idx) + 1 < samples_per_pixel()) begin
         sample_idx++;
         return;
      end
      px.red   = resolve_channel(red_acc, weight_acc);
      px.green = resolve_channel(green_acc, weight_acc);
      px.blue  = resolve_channel(blue_acc, weight_acc);
      last_col = int'(pix_col) + 1 >= clamp_size(model_cfg.frame_width, DEF_MAX_WIDTH);
      last_row = int'(pix_row) + 1 >= clamp_size(model_cfg.frame_height, DEF_MAX_HEIGHT);
      px.frame_end = last_col && last_row;
      expected_pixels.push_back(px);
      if (last_col) begin
         pix_col = '0;
         pix_row = last_row ? '0 : pix_row + 1'b1;
      end else begin
         pix_col = pix_col + 1'b1;
      end
      sample_idx = '0;
      red_acc    = '0;
      green_acc  = '0;
      blue_acc   = '0;
      weight_acc = '0;
   endfunction

   function automatic chan_type rand_chan();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return chan_type'($urandom);
      endcase
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return W_ONE;
         2: return $urandom_range(W_ONE + 1, 511);
         default: return $urandom_range(0, W_ONE);
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return DEF_MAX_WIDTH;
         2: return $urandom_range(DEF_MAX_WIDTH + 1, 8191);
         3, 4: return 2 * $urandom_range(0, 4) + 1;
         default: return 2 * $urandom_range(1, 4);
      endcase
   endfunction

   task automatic send_sample(input chan_type r, input chan_type g, input chan_type b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_bus.valid    <= 1'b1;
      req_bus.red_in   <= r;
      req_bus.green_in <= g;
      req_bus.blue_in  <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      fold_sample(r, g, b);
      samples_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random_sample();
      send_sample(rand_chan(), rand_chan(), rand_chan());
   endtask

   // drop valid, drain pending pixels and let the divider finish
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_SAMPLE_COUNT: model_cfg.sample_count = value[CNT_CFG_W-1:0];
         REG_WEIGHT_ZERO:  model_cfg.weight[0]    = value[W_W-1:0];
         REG_WEIGHT_ONE:   model_cfg.weight[1]    = value[W_W-1:0];
         REG_WEIGHT_TWO:   model_cfg.weight[2]    = value[W_W-1:0];
         REG_WEIGHT_THREE: model_cfg.weight[3]    = value[W_W-1:0];
         REG_FRAME_WIDTH:  model_cfg.frame_width  = value[SIZE_CFG_W-1:0];
         REG_FRAME_HEIGHT: model_cfg.frame_height = value[SIZE_CFG_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'h5555, 16'hAAAA, 16'h0F0F);
      send_sample(16'hAAAA, 16'h5555, 16'hF0F0);
      quiesce();
   endtask

   task automatic test_weight_mix();
      write_reg(REG_SAMPLE_COUNT, 4);
      write_reg(REG_WEIGHT_ZERO, 511);
      write_reg(REG_WEIGHT_ONE, 0);
      write_reg(REG_WEIGHT_TWO, 128);
      write_reg(REG_WEIGHT_THREE, 1);
      send_sample(16'hFFFF, 16'h0000, 16'h1234);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'h0000, 16'hFFFF, 16'h8000);
      send_sample(16'h0001, 16'h7FFF, 16'hFFFF);
      quiesce();
   endtask

   task automatic test_zero_weight_total();
      write_reg(REG_SAMPLE_COUNT, 2);
      write_reg(REG_WEIGHT_ZERO, 0);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'h8001, 16'h4002, 16'h2004);
      quiesce();
   endtask

   task automatic test_count_limits();
      write_reg(REG_WEIGHT_ZERO, 256);
      write_reg(REG_WEIGHT_ONE, 64);
      write_reg(REG_WEIGHT_TWO, 200);
      write_reg(REG_WEIGHT_THREE, 256);
      write_reg(REG_SAMPLE_COUNT, 0);
      send_sample(16'h1357, 16'hFFFF, 16'h0000);
      quiesce();
      write_reg(REG_SAMPLE_COUNT, 7);
      repeat (4) send_random_sample();
      quiesce();
   endtask

   task automatic test_frame_sizes();
      write_reg(REG_SAMPLE_COUNT, 1);
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_HEIGHT, 0);
      send_random_sample();
      quiesce();
      write_reg(REG_FRAME_WIDTH, DEF_MAX_WIDTH);
      write_reg(REG_FRAME_HEIGHT, DEF_MAX_HEIGHT);
      repeat (2) send_random_sample();
      quiesce();
      write_reg(REG_FRAME_WIDTH, 8191);
      write_reg(REG_FRAME_HEIGHT, 8191);
      send_random_sample();
      quiesce();
   endtask

   task automatic test_mid_pixel_change();
      write_reg(REG_FRAME_WIDTH, 2);
      write_reg(REG_FRAME_HEIGHT, 2);
      write_reg(REG_SAMPLE_COUNT, 4);
      repeat (3) send_random_sample();
      quiesce();
      write_reg(REG_SAMPLE_COUNT, 2);
      send_random_sample();
      quiesce();
   endtask

   task automatic test_output_backpressure();
      write_reg(REG_SAMPLE_COUNT, 1);
      write_reg(REG_FRAME_WIDTH, 4);
      write_reg(REG_FRAME_HEIGHT, 4);
      hold_requests++;
      repeat (40) send_random_sample();
      quiesce();
   endtask

   task automatic test_random_frames();
      int pixels;
      int spp;
      while (samples_sent < SAMPLE_TARGET) begin
         quiesce();
         if ($urandom_range(0, 1))
            write_reg(REG_SAMPLE_COUNT, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(0, 7) : $urandom_range(1, 4));
         if ($urandom_range(0, 1)) write_reg(REG_WEIGHT_ZERO, pick_weight());
         if ($urandom_range(0, 1)) write_reg(REG_WEIGHT_ONE, pick_weight());
         if ($urandom_range(0, 1)) write_reg(REG_WEIGHT_TWO, pick_weight());
         if ($urandom_range(0, 1)) write_reg(REG_WEIGHT_THREE, pick_weight());
         if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME_WIDTH, pick_size());
         if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME_HEIGHT, pick_size());
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_random_sample();
         pixels = $urandom_range(2, 16);
         repeat (pixels) begin
            spp = samples_per_pixel();
            spp = (sample_idx >= spp) ? 1 : spp - sample_idx;
            repeat (spp) send_random_sample();
         end
      end
      quiesce();
   endtask

   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      stall_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_bus.ready <= (stall_phase % 5) != 0;
         endcase
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel: red %h green %h blue %h frame_end %b",
                   rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.frame_end);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_bus.frame_end) frame_ends++;
            if (rsp_bus.red_out !== want.red) begin
               $error("red_out: expected %h, actual %h", want.red, rsp_bus.red_out);
               fail_count++;
            end
            if (rsp_bus.green_out !== want.green) begin
               $error("green_out: expected %h, actual %h", want.green, rsp_bus.green_out);
               fail_count++;
            end
            if (rsp_bus.blue_out !== want.blue) begin
               $error("blue_out: expected %h, actual %h", want.blue, rsp_bus.blue_out);
               fail_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, actual %b", want.frame_end, rsp_bus.frame_end);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = REG_SAMPLE_COUNT;
      csr_bus.data     = '0;
      model_cfg.sample_count = RST_SAMPLE_COUNT;
      model_cfg.weight       = {NUM_WEIGHT{RST_WEIGHT}};
      model_cfg.frame_width  = RST_FRAME_SIZE;
      model_cfg.frame_height = RST_FRAME_SIZE;
      sample_idx = '0;
      pix_col    = '0;
      pix_row    = '0;
      red_acc    = '0;
      green_acc  = '0;
      blue_acc   = '0;
      weight_acc = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_weight_mix();
      test_zero_weight_total();
      test_count_limits();
      test_frame_sizes();
      test_mid_pixel_change();
      test_output_backpressure();
      test_random_frames();

      $display("run covered %0d samples and %0d resolved pixels (%0d frame ends)",
               samples_sent, pixels_checked, frame_ends);
      $display("%0d register writes, %0d mismatches", csr_writes, fail_count);
      if (fail_count == 0) begin
         $display("msaa_weighted_resolve_tb: PASS");
      end else begin
         $display("msaa_weighted_resolve_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("timeout: %0d pixels still pending", expected_pixels.size());
      $display("msaa_weighted_resolve_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/msaa_pkg.sv
src/msaa_req_if.sv
src/msaa_rsp_if.sv
src/msaa_csr_if.sv
src/msaa_csr.sv
src/msaa_ctrl.sv
src/msaa_dp.sv
src/msaa_weighted_resolve.sv
sim/msaa_weighted_resolve_tb.sv
